FILE: hw/rtl/brsl_pkg.sv
// ----------------------------------------------------------------------------
// brsl_pkg
// Shared types, constants and tables of the reverse string lookup block.
// ----------------------------------------------------------------------------
package brsl_pkg;

	localparam int MODULUS    = 65521;
	localparam int MAX_LEN    = 128;
	localparam int NUM_HASHES = 5;

	// hash values live below 2^HASH_W; reduction folds the high half with
	// FOLD_K = 2^HASH_W - MODULUS, so MODULUS sits just under 2^HASH_W
	localparam int HASH_W = 16;
	localparam int FOLD_K = (1 << HASH_W) - MODULUS;

	localparam int BANK_W      = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
	localparam int BLOOM_DEPTH = NUM_HASHES << HASH_W;
	localparam int BLOOM_AW    = $clog2(BLOOM_DEPTH);
	localparam int BUF_AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W       = $clog2(MAX_LEN + 1);

	typedef logic [1:0]        opcode_t;
	typedef logic [2:0]        status_t;
	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [BANK_W-1:0] bank_t;
	typedef logic [1:0]        kind_t;

	localparam opcode_t OP_INSERT = 2'd0;
	localparam opcode_t OP_QUERY  = 2'd1;
	localparam opcode_t OP_CLEAR  = 2'd2;
	localparam opcode_t OP_NONE   = 2'd3;

	localparam status_t ST_INSERTED   = 3'd0;
	localparam status_t ST_PRESENT    = 3'd1;
	localparam status_t ST_ABSENT     = 3'd2;
	localparam status_t ST_PALINDROME = 3'd3;
	localparam status_t ST_TOO_LONG   = 3'd4;
	localparam status_t ST_CLEARED    = 3'd5;

	// modmul operation kinds
	localparam kind_t K_FWD = 2'd0;
	localparam kind_t K_POW = 2'd1;
	localparam kind_t K_REV = 2'd2;

	typedef struct packed {
		bank_t bank;
		kind_t kind;
	} mm_tag_t;

	typedef struct packed {
		logic    valid;
		hash_t   a;
		hash_t   b;
		hash_t   addend;
		mm_tag_t tag;
	} mm_req_t;

	typedef struct packed {
		logic    valid;
		hash_t   value;
		mm_tag_t tag;
	} mm_rsp_t;

	function automatic hash_t bank_prime(bank_t bank);
		hash_t p;
		case (bank)
			BANK_W'(0): p = hash_t'(3);
			BANK_W'(1): p = hash_t'(11);
			BANK_W'(2): p = hash_t'(31);
			BANK_W'(3): p = hash_t'(101);
			BANK_W'(4): p = hash_t'(113);
			default:    p = hash_t'(3);
		endcase
		return p;
	endfunction

	// A-Z -> 26..51, a-z -> 0..25, others wrap modulo MODULUS
	function automatic hash_t letter_value(logic [7:0] c);
		hash_t v;
		if (c <= 8'd90) begin
			if (c >= 8'd39)
				v = hash_t'(c - 8'd39);
			else
				v = hash_t'(MODULUS) - hash_t'(8'd39 - c);
		end else begin
			if (c >= 8'd97)
				v = hash_t'(c - 8'd97);
			else
				v = hash_t'(MODULUS) - hash_t'(8'd97 - c);
		end
		return v;
	endfunction

endpackage

FILE: hw/rtl/brsl_in_if.sv
// ----------------------------------------------------------------------------
// brsl_in_if
// Character channel: one string character with opcode and end mark per item.
// ----------------------------------------------------------------------------
interface brsl_in_if;
	import brsl_pkg::*;

	logic       valid;
	logic       ready;
	opcode_t    opcode;
	logic [7:0] char_code;
	logic       last_char;

	modport source(output valid, output opcode, output char_code, output last_char,
		input ready);
	modport sink(input valid, input opcode, input char_code, input last_char,
		output ready);
endinterface

FILE: hw/rtl/brsl_out_if.sv
// ----------------------------------------------------------------------------
// brsl_out_if
// Result channel: status code and sticky found flag per item.
// ----------------------------------------------------------------------------
interface brsl_out_if;
	import brsl_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	logic    found_any;

	modport source(output valid, output status, output found_any, input ready);
	modport sink(input valid, input status, input found_any, output ready);
endinterface

FILE: hw/rtl/brsl_ram.sv
// ----------------------------------------------------------------------------
// brsl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brsl_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hw/rtl/brsl_modmul.sv
// ----------------------------------------------------------------------------
// brsl_modmul
// Shared modular multiply-add: (a * b + addend) mod MODULUS; product registered, then folded.
// ----------------------------------------------------------------------------
module brsl_modmul (
	input  logic              clk,
	input  logic              arst_n,
	input  brsl_pkg::mm_req_t req,
	output brsl_pkg::mm_rsp_t rsp
);
	import brsl_pkg::*;

	logic                  vld_s1;
	logic [2*HASH_W-1:0]   prod_s1;
	hash_t                 add_s1;
	mm_tag_t               tag_s1;

	logic [2*HASH_W-1:0]   sum;
	logic [HASH_W+3:0]     fold1;
	logic [HASH_W:0]       fold2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			prod_s1 <= req.a * req.b;
			add_s1  <= req.addend;
			tag_s1  <= req.tag;
		end
	end

	// product + addend stays below 2^32; two folds leave less than 2*MODULUS
	always_comb begin
		sum   = prod_s1 + (2*HASH_W)'(add_s1);
		fold1 = (HASH_W+4)'(sum[2*HASH_W-1:HASH_W] * FOLD_K)
			+ (HASH_W+4)'(sum[HASH_W-1:0]);
		fold2 = (HASH_W+1)'(fold1[HASH_W+3:HASH_W] * FOLD_K)
			+ (HASH_W+1)'(fold1[HASH_W-1:0]);
		rsp.valid = vld_s1;
		rsp.tag   = tag_s1;
		if (fold2 >= (HASH_W+1)'(MODULUS))
			rsp.value = HASH_W'(fold2 - (HASH_W+1)'(MODULUS));
		else
			rsp.value = HASH_W'(fold2);
	end
endmodule

FILE: hw/rtl/bloom_reverse_string_lookup.sv
// ----------------------------------------------------------------------------
// bloom_reverse_string_lookup
// Bloom filter over letter strings with forward and reversed polynomial
// hashes; queries report whether the reverse of a string was inserted.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                          | handshake
//  chars    | in  | opcode, char_code, last_char     | valid/ready
//  results  | out | status, found_any                | valid/ready
//
//  A character is accepted, then takes 15 modmul issues (3 per bank) and a drain;
//  one past MAX_LEN takes the accept only. A string end adds an evaluate step,
//  then 5 store writes (insert) or, per buffer pair, S_PAL_A/B/C and, per bank,
//  S_QRY_A/B (query), then a load of the result register. Reset and each clear run
//  a pass over all 327680 addresses (BLOOM_DEPTH) zeroing the store with chars.ready low.
//  A stalled result only holds the block in its final cycle.
// ----------------------------------------------------------------------------
module bloom_reverse_string_lookup (
	input logic        clk,
	input logic        arst_n,
	brsl_in_if.sink    chars,
	brsl_out_if.source results
);
	import brsl_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_HASH  = 4'd2;
	localparam logic [3:0] S_DRAIN = 4'd3;
	localparam logic [3:0] S_EVAL  = 4'd4;
	localparam logic [3:0] S_INS   = 4'd5;
	localparam logic [3:0] S_PAL_A = 4'd6;
	localparam logic [3:0] S_PAL_B = 4'd7;
	localparam logic [3:0] S_PAL_C = 4'd8;
	localparam logic [3:0] S_QRY_A = 4'd9;
	localparam logic [3:0] S_QRY_B = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0]          state_q;
	logic [BLOOM_AW-1:0] clr_q;
	logic                pend_q;
	opcode_t             op_q;
	logic                last_q;
	hash_t               v_q;
	logic [CNT_W-1:0]    count_q;
	logic                too_long_q;
	bank_t               j_q;
	kind_t               k_q;
	hash_t               fwd_q [NUM_HASHES];
	hash_t               rev_q [NUM_HASHES];
	hash_t               pow_q [NUM_HASHES];
	logic                found_q;
	logic                hit_q;
	logic [BUF_AW-1:0]   pa_q;
	logic [BUF_AW-1:0]   pb_q;
	logic [7:0]          ca_q;
	status_t             stat_q;
	logic                res_valid_q;
	status_t             res_status_q;
	logic                res_found_q;

	logic                acc;
	mm_req_t             mm_req;
	mm_rsp_t             mm_rsp;
	logic                bloom_we;
	logic [BLOOM_AW-1:0] bloom_waddr;
	logic [BLOOM_AW-1:0] bloom_raddr;
	logic                bloom_rdata;
	logic                buf_we;
	logic [BUF_AW-1:0]   buf_raddr;
	logic [7:0]          buf_rdata;

	assign chars.ready       = (state_q == S_IDLE);
	assign acc               = chars.valid && chars.ready;
	assign results.valid     = res_valid_q;
	assign results.status    = res_status_q;
	assign results.found_any = res_found_q;

	always_comb begin
		mm_req.valid    = (state_q == S_HASH);
		mm_req.tag.bank = j_q;
		mm_req.tag.kind = k_q;
		case (k_q)
			K_FWD: begin
				mm_req.a      = v_q;
				mm_req.b      = pow_q[j_q];
				mm_req.addend = fwd_q[j_q];
			end
			K_POW: begin
				mm_req.a      = pow_q[j_q];
				mm_req.b      = bank_prime(j_q);
				mm_req.addend = '0;
			end
			default: begin
				mm_req.a      = rev_q[j_q];
				mm_req.b      = bank_prime(j_q);
				mm_req.addend = v_q;
			end
		endcase
	end

	brsl_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	assign bloom_we    = (state_q == S_CLEAR) || (state_q == S_INS);
	assign bloom_waddr = (state_q == S_CLEAR) ? clr_q : BLOOM_AW'({j_q, fwd_q[j_q]});
	assign bloom_raddr = BLOOM_AW'({j_q, rev_q[j_q]});

	brsl_ram #(.WIDTH(1), .DEPTH(BLOOM_DEPTH)) u_bloom (
		.clk   (clk),
		.we    (bloom_we),
		.waddr (bloom_waddr),
		.wdata (state_q == S_INS),
		.raddr (bloom_raddr),
		.rdata (bloom_rdata)
	);

	assign buf_we    = acc && (chars.opcode == OP_INSERT || chars.opcode == OP_QUERY)
		&& (count_q < CNT_W'(MAX_LEN));
	assign buf_raddr = (state_q == S_PAL_B) ? pb_q : pa_q;

	brsl_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_chbuf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (count_q[BUF_AW-1:0]),
		.wdata (chars.char_code),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			count_q     <= '0;
			too_long_q  <= 1'b0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
			j_q         <= '0;
			k_q         <= K_FWD;
			for (int i = 0; i < NUM_HASHES; i++) begin
				fwd_q[i] <= '0;
				rev_q[i] <= '0;
				pow_q[i] <= hash_t'(1);
			end
		end else begin
			if (res_valid_q && results.ready && (state_q != S_OUT))
				res_valid_q <= 1'b0;

			if (mm_rsp.valid) begin
				case (mm_rsp.tag.kind)
					K_FWD:   fwd_q[mm_rsp.tag.bank] <= mm_rsp.value;
					K_POW:   pow_q[mm_rsp.tag.bank] <= mm_rsp.value;
					default: rev_q[mm_rsp.tag.bank] <= mm_rsp.value;
				endcase
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BLOOM_AW'(BLOOM_DEPTH - 1)) begin
						pend_q <= 1'b0;
						stat_q <= ST_CLEARED;
						state_q <= pend_q ? S_OUT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						op_q   <= chars.opcode;
						last_q <= chars.last_char;
						v_q    <= letter_value(chars.char_code);
						case (chars.opcode)
							OP_CLEAR: begin
								found_q    <= 1'b0;
								count_q    <= '0;
								too_long_q <= 1'b0;
								for (int i = 0; i < NUM_HASHES; i++) begin
									fwd_q[i] <= '0;
									rev_q[i] <= '0;
									pow_q[i] <= hash_t'(1);
								end
								clr_q   <= '0;
								pend_q  <= 1'b1;
								state_q <= S_CLEAR;
							end
							OP_NONE: state_q <= S_IDLE;
							default: begin
								if (count_q < CNT_W'(MAX_LEN)) begin
									count_q <= count_q + 1'b1;
									j_q     <= '0;
									k_q     <= K_FWD;
									state_q <= S_HASH;
								end else begin
									too_long_q <= 1'b1;
									state_q    <= chars.last_char ? S_EVAL : S_IDLE;
								end
							end
						endcase
					end
				end
				S_HASH: begin
					if (k_q == K_REV) begin
						k_q <= K_FWD;
						if (j_q == BANK_W'(NUM_HASHES - 1))
							state_q <= S_DRAIN;
						else
							j_q <= j_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DRAIN: state_q <= last_q ? S_EVAL : S_IDLE;
				S_EVAL: begin
					j_q <= '0;
					if (too_long_q) begin
						stat_q  <= ST_TOO_LONG;
						state_q <= S_OUT;
					end else if (op_q == OP_INSERT) begin
						state_q <= S_INS;
					end else if (count_q <= CNT_W'(1)) begin
						stat_q  <= ST_PALINDROME;
						state_q <= S_OUT;
					end else begin
						pa_q    <= '0;
						pb_q    <= BUF_AW'(count_q - 1'b1);
						state_q <= S_PAL_A;
					end
				end
				S_INS: begin
					if (j_q == BANK_W'(NUM_HASHES - 1)) begin
						stat_q  <= ST_INSERTED;
						state_q <= S_OUT;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_PAL_A: state_q <= S_PAL_B;
				S_PAL_B: begin
					ca_q    <= buf_rdata;
					state_q <= S_PAL_C;
				end
				S_PAL_C: begin
					if (ca_q != buf_rdata) begin
						j_q     <= '0;
						hit_q   <= 1'b1;
						state_q <= S_QRY_A;
					end else if (({1'b0, pa_q} + 2'd2) < {1'b0, pb_q}) begin
						pa_q    <= pa_q + 1'b1;
						pb_q    <= pb_q - 1'b1;
						state_q <= S_PAL_A;
					end else begin
						stat_q  <= ST_PALINDROME;
						state_q <= S_OUT;
					end
				end
				S_QRY_A: state_q <= S_QRY_B;
				S_QRY_B: begin
					hit_q <= hit_q & bloom_rdata;
					if (j_q == BANK_W'(NUM_HASHES - 1)) begin
						if (hit_q && bloom_rdata) begin
							found_q <= 1'b1;
							stat_q  <= ST_PRESENT;
						end else begin
							stat_q  <= ST_ABSENT;
						end
						state_q <= S_OUT;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_QRY_A;
					end
				end
				S_OUT: begin
					if (!res_valid_q || results.ready) begin
						res_valid_q  <= 1'b1;
						res_status_q <= stat_q;
						res_found_q  <= found_q;
						count_q      <= '0;
						too_long_q   <= 1'b0;
						for (int i = 0; i < NUM_HASHES; i++) begin
							fwd_q[i] <= '0;
							rev_q[i] <= '0;
							pow_q[i] <= hash_t'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LEN))
		else $error("character count beyond buffer");

	a_mm_rsp_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.valid |-> $past(state_q == S_HASH))
		else $error("modmul response without issue");

	a_pal_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAL_A) |-> (pa_q < pb_q))
		else $error("palindrome walk crossed");

	a_cleared_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_status_q == ST_CLEARED) |-> !res_found_q)
		else $error("clear result with found flag set");
`endif
endmodule
